// File: design/tspp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspp_pkg
// Shared codes, constants, types and the shade colour table of the tile and
// sprite pixel pipeline.
// ----------------------------------------------------------------------------
package tspp_pkg;

  // Memory geometry
  localparam int VIDEO_BYTES  = 8192;
  localparam int VADDR_W      = 13;
  localparam int OBJECT_BYTES = 160;
  localparam int OADDR_W      = 8;
  localparam int OBJ_TOTAL    = 40;

  // Timing constants
  localparam int LINES_PER_FRAME = 154;
  localparam int SCAN_LAST_DOT   = 79;
  localparam logic [3:0] MIX_WARMUP     = 4'd12;
  localparam logic [2:0] BG_FIRST_DELAY = 3'd5;
  localparam logic [7:0] OBJ_Y_OFFSET   = 8'd16;
  localparam logic [7:0] STAT_WR_MASK   = 8'b0111_1000;

  // Base addresses inside video memory
  localparam logic [VADDR_W-1:0] MAP_LOW_BASE  = 13'h1800;
  localparam logic [VADDR_W-1:0] MAP_HIGH_BASE = 13'h1C00;
  localparam logic [VADDR_W-1:0] SIGNED_BASE   = 13'h1000;

  // Command codes
  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_REG_RD = 3'd1;
  localparam logic [2:0] CMD_REG_WR = 3'd2;
  localparam logic [2:0] CMD_VID_RD = 3'd3;
  localparam logic [2:0] CMD_VID_WR = 3'd4;
  localparam logic [2:0] CMD_OBJ_RD = 3'd5;
  localparam logic [2:0] CMD_OBJ_WR = 3'd6;

  // Display modes
  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_SCAN   = 2'd2;
  localparam logic [1:0] MODE_DRAW   = 2'd3;

  // LCD register indexes
  localparam logic [3:0] REG_LCDC = 4'd0;
  localparam logic [3:0] REG_STAT = 4'd1;
  localparam logic [3:0] REG_SCY  = 4'd2;
  localparam logic [3:0] REG_SCX  = 4'd3;
  localparam logic [3:0] REG_LY   = 4'd4;
  localparam logic [3:0] REG_LYC  = 4'd5;
  localparam logic [3:0] REG_BGP  = 4'd7;
  localparam logic [3:0] REG_OBP0 = 4'd8;
  localparam logic [3:0] REG_OBP1 = 4'd9;
  localparam logic [3:0] REG_WY   = 4'd10;
  localparam logic [3:0] REG_WX   = 4'd11;

  localparam logic [15:0] REG_FIRST_ADDR = 16'hFF40;
  localparam logic [15:0] REG_LAST_ADDR  = 16'hFF4B;
  localparam logic [15:0] REG_HOLE_ADDR  = 16'hFF46;

  // Fetcher phases
  typedef enum logic [2:0] {
    PH_TILE, PH_LOW, PH_HIGH, PH_PUSH, PH_CHECK, PH_IDLE
  } phase_t;

  // Registers the pixel mixer needs
  typedef struct packed {
    logic [7:0] lcdc;
    logic [7:0] bgp;
    logic [7:0] obp0;
    logic [7:0] obp1;
  } pal_t;

  // Fixed colour of each shade
  function automatic logic [23:0] shade_rgb(input logic [1:0] shade);
    logic [23:0] rgb;
    case (shade)
      2'd0:    rgb = 24'hF4FFBF;
      2'd1:    rgb = 24'h9AD941;
      2'd2:    rgb = 24'h608057;
      default: rgb = 24'h002B40;
    endcase
    return rgb;
  endfunction

endpackage

// File: design/tspp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspp_ram
// Single-port synchronous RAM with one write or read per cycle and a
// registered read port.
// ----------------------------------------------------------------------------
module tspp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, or read into the registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: design/tspp_pix_mix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspp_pix_mix
// Priority mixing of one background and one object pixel through the
// palettes, giving the shade and its colour.
// ----------------------------------------------------------------------------
module tspp_pix_mix (
  input  tspp_pkg::pal_t pal,
  input  logic [3:0]     obj_px,   // colour[1:0], palette[2], behind[3]
  input  logic [1:0]     bg_px,
  output logic [1:0]     shade,
  output logic [23:0]    rgb
);
  import tspp_pkg::*;

  logic [1:0] oc;
  logic [7:0] obp;

  assign oc  = obj_px[1:0];
  assign obp = obj_px[2] ? pal.obp1 : pal.obp0;

  // Background wins, when enabled, if objects are off, transparent or behind a nonzero background pixel
  always_comb begin
    if (pal.lcdc[0] && (!pal.lcdc[1] || oc == 2'd0 || (obj_px[3] && bg_px != 2'd0))) begin
      shade = 2'(pal.bgp >> {bg_px, 1'b0});
    end else if (pal.lcdc[1] && oc != 2'd0) begin
      shade = 2'(obp >> {oc, 1'b0});
    end else begin
      shade = 2'd0;
    end
  end

  assign rgb = shade_rgb(shade);

endmodule

// File: design/tile_sprite_pixel_pipeline_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_sprite_pixel_pipeline_core
// LCD pixel pipeline: dot ticks and CPU accesses in, one result word out.
// ----------------------------------------------------------------------------
// Usage:
//   Each input word carries a command in s_tuser and an address and write
//   byte in s_tdata. A tick command advances the dot counter and runs object
//   scan, drawing or blanking; the other commands read or write video memory,
//   object memory or the LCD registers. Every input word gives exactly one
//   output word holding the read byte, the drawn pixel if any, the interrupt
//   pulses and the display mode after the word.
//   Items are handled one at a time by a sequencer around two single-port
//   memories. A tick in drawing is lengthened by the serial object-memory
//   reads of the object X search. A finished word waits in the output
//   register; the next input word is taken meanwhile and its result waits
//   for the register to be freed.
//   After reset both memories are cleared, one video byte a cycle, and
//   s_tready stays low until the clear is done.
// ----------------------------------------------------------------------------
module tile_sprite_pixel_pipeline_core #(
  parameter int OBJECTS_PER_LINE = 10,
  parameter int SCREEN_WIDTH     = 160,
  parameter int SCREEN_HEIGHT    = 144,
  parameter int DOTS_PER_LINE    = 456
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // address[15:0], write_data[23:16]
  input  logic [2:0]  s_tuser,   // cmd[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata    // read_data[7:0], pixel_valid[8], pixel_x[16:9],
                                 // pixel_y[24:17], pixel_shade[26:25],
                                 // pixel_rgb[50:27], irq_vblank[51],
                                 // irq_line_match[52], display_mode[54:53], zero[55]
);
  import tspp_pkg::*;

  localparam int CW = $clog2(OBJECTS_PER_LINE + 1);
  localparam int IW = (OBJECTS_PER_LINE > 1) ? $clog2(OBJECTS_PER_LINE) : 1;
  localparam int DW = $clog2(DOTS_PER_LINE);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_RDV, S_RDO,
    S_SCAN_X, S_SCAN_Y, S_SCAN_END,
    S_OBJ, S_CHK, S_CHK_X, S_OTILE, S_OY, S_OF, S_OV, S_OBJ_DONE,
    S_BG, S_BTILE, S_BDATA, S_MIX, S_LINE, S_FINISH
  } state_t;

  state_t state;

  // Latched input word
  logic [2:0]  cmd_r;
  logic [15:0] addr_r;
  logic [7:0]  wdata_r;

  // LCD registers
  logic [7:0] lcdc, stat, scy, scx, ly, lyc, bgp, obp0, obp1, wy, wx;

  // Counters and object list
  logic [DW-1:0]  dot;
  logic [7:0]     pc;
  logic [5:0]     lobj [OBJECTS_PER_LINE];
  logic [CW-1:0]  lcount;
  logic [OBJECTS_PER_LINE-1:0] used;

  // Background fetcher
  phase_t     bphase;
  logic [2:0] bdelay;
  logic [7:0] blo, bhi, btile;
  logic [3:0] bcount;
  logic [9:0] map_pos;

  // Object fetcher
  phase_t        ophase;
  logic          odelay;
  logic [7:0]    olo, otile, oy, oflags;
  logic [CW-1:0] searched;

  // Pixel queues and mixer counters
  logic [1:0] bq [8];
  logic [3:0] oq [8];
  logic [3:0] warmup;
  logic [2:0] discard;

  // Window
  logic       wactive, warmed;
  logic [7:0] wline;

  // Result being built
  logic [7:0]  res_rd, res_x, res_y;
  logic        res_pv, res_vb, res_lm;
  logic [1:0]  res_shade;
  logic [23:0] res_rgb;

  // Clearing pass
  logic [VADDR_W-1:0] clr;

  // Memory ports
  logic               vid_we, obj_we;
  logic [VADDR_W-1:0] vid_addr;
  logic [OADDR_W-1:0] obj_addr;
  logic [7:0]         vid_wdata, obj_wdata, vid_q, obj_q;

  tspp_ram #(.WIDTH(8), .DEPTH(VIDEO_BYTES)) u_vid_ram (
    .clk(clk), .we(vid_we), .addr(vid_addr), .wdata(vid_wdata), .rdata(vid_q)
  );

  tspp_ram #(.WIDTH(8), .DEPTH(OBJECT_BYTES)) u_obj_ram (
    .clk(clk), .we(obj_we), .addr(obj_addr), .wdata(obj_wdata), .rdata(obj_q)
  );

  // Decode of the latched word
  logic [1:0]  mode;
  logic        reg_ok, off_ok;
  logic [3:0]  r_idx;
  logic [7:0]  reg_rd;
  assign mode   = stat[1:0];
  assign r_idx  = addr_r[3:0];
  assign reg_ok = addr_r >= REG_FIRST_ADDR && addr_r <= REG_LAST_ADDR &&
                  addr_r != REG_HOLE_ADDR;
  assign off_ok = addr_r[7:0] < 8'(OBJECT_BYTES);

  always_comb begin
    unique case (r_idx)
      REG_LCDC: reg_rd = lcdc;
      REG_STAT: reg_rd = stat | 8'h80;
      REG_SCY:  reg_rd = scy;
      REG_SCX:  reg_rd = scx;
      REG_LY:   reg_rd = ly;
      REG_LYC:  reg_rd = lyc;
      REG_BGP:  reg_rd = bgp;
      REG_OBP0: reg_rd = obp0;
      REG_OBP1: reg_rd = obp1;
      REG_WY:   reg_rd = wy;
      REG_WX:   reg_rd = wx;
      default:  reg_rd = 8'hFF;
    endcase
  end

  // Object scan
  logic [DW-2:0] scan_idx;
  logic          scan_ok;
  logic [8:0]    scan_line, scan_y, scan_end;
  assign scan_idx  = dot[DW-1:1];
  assign scan_ok   = !dot[0] && scan_idx < (DW-1)'(OBJ_TOTAL) &&
                     lcount < CW'(OBJECTS_PER_LINE);
  assign scan_line = {1'b0, ly} + 9'd16;
  assign scan_y    = {1'b0, obj_q};
  assign scan_end  = scan_y + (lcdc[2] ? 9'd16 : 9'd8);

  // Object fetcher helpers
  logic          s_ok, s_used, chk_hit;
  logic [IW-1:0] s_idx;
  logic [5:0]    e_obj;
  logic [7:0]    odiff;
  logic [3:0]    orow_raw, orow;
  logic [VADDR_W-1:0] oaddr_lo, oaddr;
  assign s_ok    = searched < CW'(OBJECTS_PER_LINE);
  assign s_idx   = searched[IW-1:0];
  assign e_obj   = s_ok ? lobj[s_idx] : 6'd0;
  assign s_used  = s_ok ? used[s_idx] : 1'b1;
  assign chk_hit = {1'b0, obj_q} <= {1'b0, pc} + 9'd8;
  assign odiff   = ly + OBJ_Y_OFFSET - oy;
  assign orow_raw = lcdc[2] ? odiff[3:0] : {1'b0, odiff[2:0]};
  assign orow    = obj_q[6] ? ((lcdc[2] ? 4'd15 : 4'd7) - orow_raw) : orow_raw;
  assign oaddr_lo = {1'b0, otile, 4'b0} + {8'b0, orow, 1'b0};
  assign oaddr   = oaddr_lo + ((ophase == PH_HIGH) ? 13'd1 : 13'd0);

  // Background fetcher helpers
  logic [7:0]         sy;
  logic [3:0]         brow2;
  logic [VADDR_W-1:0] bbase, baddr, map_addr;
  assign sy    = ly + scy;
  assign brow2 = wactive ? {wline[2:0], 1'b0} : {sy[2:0], 1'b0};
  assign bbase = (lcdc[4] || btile[7]) ? {1'b0, btile, 4'b0}
                                       : SIGNED_BASE + {1'b0, btile, 4'b0};
  assign baddr = bbase + {9'b0, brow2} + ((bphase == PH_HIGH) ? 13'd1 : 13'd0);
  assign map_addr = ((wactive ? lcdc[6] : lcdc[3]) ? MAP_HIGH_BASE : MAP_LOW_BASE) +
                    {3'b0, map_pos};

  // Window start checks
  logic [7:0] pc_inc;
  logic       win_begin, win_mix;
  assign pc_inc    = pc + 8'd1;
  assign win_begin = warmed && lcdc[5] && 9'd7 >= {1'b0, wx};
  assign win_mix   = !wactive && warmed && lcdc[5] && ({1'b0, pc_inc} + 9'd7 >= {1'b0, wx});

  // Object row merged into the object queue, left-clipped objects lose pixels
  logic [3:0] oq_merged [8];
  logic [3:0] oskip;
  assign oskip = (obj_q < 8'd8) ? 4'(8'd8 - obj_q) : 4'd0;
  always_comb begin
    logic [4:0] k;
    logic [2:0] bit_i;
    for (int s = 0; s < 8; s++) begin
      k     = 5'(s) + {1'b0, oskip};
      bit_i = oflags[5] ? k[2:0] : 3'(3'd7 - k[2:0]);
      if (k < 5'd8 && oq[s][1:0] == 2'd0) begin
        oq_merged[s] = {oflags[7], oflags[4], vid_q[bit_i], olo[bit_i]};
      end else begin
        oq_merged[s] = oq[s];
      end
    end
  end

  // Pixel mixing
  pal_t       pal;
  logic [1:0] mix_shade;
  logic [23:0] mix_rgb;
  assign pal = '{lcdc: lcdc, bgp: bgp, obp0: obp0, obp1: obp1};

  tspp_pix_mix u_mix (
    .pal(pal), .obj_px(oq[0]), .bg_px(bq[3'(bcount - 4'd1)]),
    .shade(mix_shade), .rgb(mix_rgb)
  );

  // Line end values
  logic [DW:0] dot_inc;
  logic [7:0]  ly_inc;
  logic        ly_wrap;
  assign dot_inc = {1'b0, dot} + 1'b1;
  assign ly_inc  = ly + 8'd1;
  assign ly_wrap = ly_inc >= 8'(LINES_PER_FRAME);

  // Memory requests issued by each state
  always_comb begin
    vid_we    = 1'b0;
    obj_we    = 1'b0;
    vid_addr  = addr_r[VADDR_W-1:0];
    obj_addr  = addr_r[OADDR_W-1:0];
    vid_wdata = wdata_r;
    obj_wdata = wdata_r;
    case (state)
      S_CLEAR: begin
        vid_we    = 1'b1;
        vid_addr  = clr;
        vid_wdata = 8'd0;
        obj_we    = clr < VADDR_W'(OBJECT_BYTES);
        obj_addr  = clr[OADDR_W-1:0];
        obj_wdata = 8'd0;
      end
      S_EXEC: begin
        if (cmd_r == CMD_VID_WR) begin
          vid_we = 1'b1;
        end
        if (cmd_r == CMD_OBJ_WR) begin
          obj_we = off_ok;
        end
        if (cmd_r == CMD_TICK) begin
          obj_addr = {scan_idx[5:0], 2'b01};
        end
      end
      S_SCAN_X: obj_addr = {scan_idx[5:0], 2'b00};
      S_OBJ:    obj_addr = {e_obj, (ophase == PH_TILE) ? 2'b10 : 2'b00};
      S_CHK:    obj_addr = {e_obj, 2'b01};
      S_OY:     obj_addr = {e_obj, 2'b11};
      S_OF: begin
        vid_addr = oaddr;
        obj_addr = {e_obj, 2'b01};
      end
      S_BG:     vid_addr = (bphase == PH_TILE) ? map_addr : baddr;
      default: ;
    endcase
  end

  assign s_tready = (state == S_IDLE);

  // Sequencer, registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr      <= '0;
      m_tvalid <= 1'b0;
      lcdc <= '0; stat <= '0; scy <= '0; scx <= '0; ly <= '0; lyc <= '0;
      bgp  <= '0; obp0 <= '0; obp1 <= '0; wy <= '0; wx <= '0;
      dot      <= '0;
      pc       <= '0;
      lcount   <= '0;
      used     <= '0;
      bphase   <= PH_TILE;
      bdelay   <= '0;
      bcount   <= '0;
      map_pos  <= '0;
      ophase   <= PH_TILE;
      odelay   <= 1'b0;
      searched <= '0;
      warmup   <= '0;
      discard  <= '0;
      wactive  <= 1'b0;
      warmed   <= 1'b0;
      wline    <= '0;
      for (int i = 0; i < OBJECTS_PER_LINE; i++) lobj[i] <= '0;
      for (int i = 0; i < 8; i++) begin
        bq[i] <= '0;
        oq[i] <= '0;
      end
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        // Clear both memories after reset
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == '1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_tvalid) begin
            cmd_r     <= s_tuser;
            addr_r    <= s_tdata[15:0];
            wdata_r   <= s_tdata[23:16];
            res_rd    <= '0;
            res_pv    <= 1'b0;
            res_x     <= '0;
            res_y     <= '0;
            res_shade <= '0;
            res_rgb   <= '0;
            res_vb    <= 1'b0;
            res_lm    <= 1'b0;
            state     <= S_EXEC;
          end
        end
        // Command decode
        S_EXEC: begin
          state <= S_FINISH;
          case (cmd_r)
            CMD_TICK: begin
              if (mode == MODE_SCAN) begin
                state <= scan_ok ? S_SCAN_X : S_SCAN_END;
              end else if (mode == MODE_DRAW) begin
                state <= (ophase != PH_IDLE) ? S_OBJ : S_BG;
              end else begin
                state <= S_LINE;
              end
            end
            CMD_REG_RD: res_rd <= reg_ok ? reg_rd : 8'hFF;
            CMD_REG_WR: begin
              if (reg_ok) begin
                case (r_idx)
                  REG_LCDC: lcdc <= wdata_r;
                  REG_STAT: stat <= (wdata_r & STAT_WR_MASK) | (stat & 8'h07);
                  REG_SCY:  scy  <= wdata_r;
                  REG_SCX:  scx  <= wdata_r;
                  REG_LYC: begin
                    lyc     <= wdata_r;
                    stat[2] <= (ly == wdata_r);
                    res_lm  <= (ly == wdata_r);
                  end
                  REG_BGP:  bgp  <= wdata_r;
                  REG_OBP0: obp0 <= wdata_r;
                  REG_OBP1: obp1 <= wdata_r;
                  REG_WY:   wy   <= wdata_r;
                  REG_WX:   wx   <= wdata_r;
                  default: ;
                endcase
              end
            end
            CMD_VID_RD: state <= S_RDV;
            CMD_OBJ_RD: begin
              if (off_ok) state <= S_RDO;
              else res_rd <= 8'hFF;
            end
            default: ;
          endcase
        end
        S_RDV: begin
          res_rd <= vid_q;
          state  <= S_FINISH;
        end
        S_RDO: begin
          res_rd <= obj_q;
          state  <= S_FINISH;
        end
        // Object scan: X first, then Y against the line
        S_SCAN_X: state <= (obj_q == 8'd0) ? S_SCAN_END : S_SCAN_Y;
        S_SCAN_Y: begin
          if (scan_y <= scan_line && scan_line < scan_end) begin
            lobj[lcount[IW-1:0]] <= scan_idx[5:0];
            lcount <= lcount + 1'b1;
          end
          state <= S_SCAN_END;
        end
        // Start of drawing at the last object-scan dot
        S_SCAN_END: begin
          if (dot == DW'(SCAN_LAST_DOT)) begin
            stat[1:0] <= MODE_DRAW;
            pc        <= '0;
            ophase    <= PH_CHECK;
            searched  <= '0;
            for (int i = 0; i < OBJECTS_PER_LINE; i++) used[i] <= CW'(i) >= lcount;
            bphase    <= PH_TILE;
            bdelay    <= BG_FIRST_DELAY;
            bcount    <= '0;
            warmup    <= MIX_WARMUP;
            for (int i = 0; i < 8; i++) oq[i] <= '0;
            wactive   <= win_begin;
            if (win_begin) begin
              map_pos <= {wline[7:3], 5'b0};
              discard <= '0;
            end else begin
              map_pos <= {sy[7:3], scx[7:3]};
              discard <= scx[2:0];
            end
          end
          state <= S_LINE;
        end
        // Object fetcher
        S_OBJ: begin
          state <= S_OBJ_DONE;
          if (odelay) begin
            odelay <= 1'b0;
          end else if (ophase == PH_CHECK) begin
            state <= S_CHK;
          end else if (!s_ok) begin
            ophase <= PH_CHECK;
          end else if (ophase == PH_TILE) begin
            state <= S_OTILE;
          end else if (ophase == PH_LOW || ophase == PH_HIGH) begin
            state <= S_OY;
          end
        end
        // Search for the next object that has reached the current column
        S_CHK: begin
          if (!s_ok) begin
            ophase <= PH_IDLE;
            state  <= S_OBJ_DONE;
          end else if (s_used) begin
            searched <= searched + 1'b1;
          end else begin
            state <= S_CHK_X;
          end
        end
        S_CHK_X: begin
          if (chk_hit) begin
            ophase       <= PH_TILE;
            used[s_idx]  <= 1'b1;
            state        <= S_OBJ_DONE;
          end else begin
            searched <= searched + 1'b1;
            state    <= S_CHK;
          end
        end
        S_OTILE: begin
          otile  <= lcdc[2] ? (obj_q & 8'hFE) : obj_q;
          ophase <= PH_LOW;
          odelay <= 1'b1;
          state  <= S_OBJ_DONE;
        end
        S_OY: begin
          oy    <= obj_q;
          state <= S_OF;
        end
        S_OF: begin
          oflags <= obj_q;
          state  <= S_OV;
        end
        S_OV: begin
          if (ophase == PH_LOW) begin
            olo    <= vid_q;
            ophase <= PH_HIGH;
            odelay <= 1'b1;
          end else begin
            for (int i = 0; i < 8; i++) oq[i] <= oq_merged[i];
            ophase <= PH_CHECK;
          end
          state <= S_OBJ_DONE;
        end
        S_OBJ_DONE: state <= (ophase == PH_IDLE) ? S_BG : S_LINE;
        // Background fetcher
        S_BG: begin
          state <= S_MIX;
          if (bdelay != 3'd0) begin
            bdelay <= bdelay - 3'd1;
          end else if (bphase == PH_TILE) begin
            state <= S_BTILE;
          end else if (bphase == PH_LOW || bphase == PH_HIGH) begin
            state <= S_BDATA;
          end else if (bphase == PH_PUSH && bcount == 4'd0) begin
            for (int i = 0; i < 8; i++) bq[i] <= {bhi[i], blo[i]};
            bcount <= 4'd8;
            bphase <= PH_TILE;
            bdelay <= 3'd1;
          end
        end
        S_BTILE: begin
          btile   <= vid_q;
          map_pos <= {map_pos[9:5], map_pos[4:0] + 5'd1};
          bphase  <= PH_LOW;
          bdelay  <= 3'd1;
          state   <= S_MIX;
        end
        S_BDATA: begin
          if (bphase == PH_LOW) begin
            blo    <= vid_q;
            bphase <= PH_HIGH;
            bdelay <= 3'd1;
          end else begin
            bhi    <= vid_q;
            bphase <= PH_PUSH;
          end
          state <= S_MIX;
        end
        // Mixer: warm-up, fine-scroll discard, then one pixel
        S_MIX: begin
          state <= S_LINE;
          if (warmup != 4'd0) begin
            warmup <= warmup - 4'd1;
            if (pc >= 8'(SCREEN_WIDTH)) stat[1:0] <= MODE_HBLANK;
          end else if (bcount == 4'd0) begin
            if (pc >= 8'(SCREEN_WIDTH)) stat[1:0] <= MODE_HBLANK;
          end else if (discard != 3'd0) begin
            discard <= discard - 3'd1;
            bcount  <= bcount - 4'd1;
            if (pc >= 8'(SCREEN_WIDTH)) stat[1:0] <= MODE_HBLANK;
          end else begin
            res_pv    <= 1'b1;
            res_x     <= pc;
            res_y     <= ly;
            res_shade <= mix_shade;
            res_rgb   <= mix_rgb;
            pc        <= pc_inc;
            if (win_mix) begin
              wactive <= 1'b1;
              map_pos <= {wline[7:3], 5'b0};
              bcount  <= '0;
              bphase  <= PH_TILE;
              bdelay  <= 3'd1;
            end else begin
              bcount <= bcount - 4'd1;
            end
            for (int i = 0; i < 7; i++) oq[i] <= oq[i+1];
            oq[7]    <= '0;
            ophase   <= PH_CHECK;
            searched <= '0;
            if (pc_inc >= 8'(SCREEN_WIDTH)) stat[1:0] <= MODE_HBLANK;
          end
        end
        // Dot and line counters, interrupts
        S_LINE: begin
          state <= S_FINISH;
          if (dot_inc >= (DW+1)'(DOTS_PER_LINE)) begin
            dot    <= '0;
            lcount <= '0;
            if (ly_wrap) begin
              ly     <= '0;
              wline  <= '0;
              warmed <= (wy == 8'd0);
            end else begin
              ly <= ly_inc;
              if (wactive) wline <= wline + 8'd1;
              if (ly_inc < 8'(SCREEN_HEIGHT) && ly_inc == wy) warmed <= 1'b1;
            end
            stat[2] <= ((ly_wrap ? 8'd0 : ly_inc) == lyc);
            res_lm  <= ((ly_wrap ? 8'd0 : ly_inc) == lyc);
            if (ly_wrap || ly_inc < 8'(SCREEN_HEIGHT)) begin
              stat[1:0] <= MODE_SCAN;
            end else if (ly_inc == 8'(SCREEN_HEIGHT)) begin
              stat[1:0] <= MODE_VBLANK;
              res_vb    <= 1'b1;
            end
          end else begin
            dot <= dot_inc[DW-1:0];
          end
        end
        // Hand the word to the output register once it is free
        S_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {1'b0, mode, res_lm, res_vb, res_rgb, res_shade,
                         res_y, res_x, res_pv, res_rd};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A drawn pixel always lies inside the visible area
  property p_pixel_inside;
    @(posedge clk) disable iff (rst)
      m_tvalid && m_tdata[8] |-> m_tdata[16:9] < 8'(SCREEN_WIDTH) &&
                                 m_tdata[24:17] < 8'(SCREEN_HEIGHT);
  endproperty
  a_pixel_inside: assert property (p_pixel_inside) else $error("pixel outside screen");

  // The object list never overfills
  property p_list_bound;
    @(posedge clk) disable iff (rst) lcount <= CW'(OBJECTS_PER_LINE);
  endproperty
  a_list_bound: assert property (p_list_bound) else $error("object list overflow");

  // The line counter stays inside the frame
  property p_line_bound;
    @(posedge clk) disable iff (rst) ly < 8'(LINES_PER_FRAME);
  endproperty
  a_line_bound: assert property (p_line_bound) else $error("line counter out of frame");

  // One word in flight: an accepted word closes the input until it is done
  property p_one_in_flight;
    @(posedge clk) disable iff (rst) s_tvalid && s_tready |=> !s_tready;
  endproperty
  a_one_in_flight: assert property (p_one_in_flight) else $error("second word accepted");

endmodule
